// ===== hdl/mlbh_pkg.sv =====
// Package for the MD5-like block hash: IV, round constants, rotate table, FSM type.
// No dependencies.
`default_nettype none
package mlbh_pkg;
   localparam logic [31:0] IV_A = 32'h67452301;
   localparam logic [31:0] IV_B = 32'hefcdab89;
   localparam logic [31:0] IV_C = 32'h98badcfe;
   localparam logic [31:0] IV_D = 32'h10325476;
   localparam logic [7:0]  PAD_MARK = 8'h80;

   typedef enum logic [2:0] {
      ST_IDLE, ST_PAD, ST_RUN, ST_ZERO, ST_OUT
   } state_type;

   typedef struct packed {
      logic       start;   // begin a 64-round compression
      logic       clear;   // zero-fill write active
   } ctl_type;

   function automatic logic [31:0] kconst(input logic [5:0] r);
      logic [31:0] k;
      begin
         case (r)
            6'd0: k=32'hd76aa478; 6'd1: k=32'he8c7b756; 6'd2: k=32'h242070db; 6'd3: k=32'hc1bdceee;
            6'd4: k=32'hf57c0faf; 6'd5: k=32'h4787c62a; 6'd6: k=32'ha8304613; 6'd7: k=32'hfd469501;
            6'd8: k=32'h698098d8; 6'd9: k=32'h8b44f7af; 6'd10: k=32'hffff5bb1; 6'd11: k=32'h895cd7be;
            6'd12: k=32'h6b901122; 6'd13: k=32'hfd987193; 6'd14: k=32'ha679438e; 6'd15: k=32'h49b40821;
            6'd16: k=32'hf61e2562; 6'd17: k=32'hc040b340; 6'd18: k=32'h265e5a51; 6'd19: k=32'he9b6c7aa;
            6'd20: k=32'hd62f105d; 6'd21: k=32'h02441453; 6'd22: k=32'hd8a1e681; 6'd23: k=32'he7d3fbc8;
            6'd24: k=32'h21e1cde6; 6'd25: k=32'hc33707d6; 6'd26: k=32'hf4d50d87; 6'd27: k=32'h455a14ed;
            6'd28: k=32'ha9e3e905; 6'd29: k=32'hfcefa3f8; 6'd30: k=32'h676f02d9; 6'd31: k=32'h8d2a4c8a;
            6'd32: k=32'hfffa3942; 6'd33: k=32'h8771f681; 6'd34: k=32'h6d9d6122; 6'd35: k=32'hfde5380c;
            6'd36: k=32'ha4beea44; 6'd37: k=32'h4bdecfa9; 6'd38: k=32'hf6bb4b60; 6'd39: k=32'hbebfbc70;
            6'd40: k=32'h289b7ec6; 6'd41: k=32'heaa127fa; 6'd42: k=32'hd4ef3085; 6'd43: k=32'h04881d05;
            6'd44: k=32'hd9d4d039; 6'd45: k=32'he6db99e5; 6'd46: k=32'h1fa27cf8; 6'd47: k=32'hc4ac5665;
            6'd48: k=32'hf4292244; 6'd49: k=32'h432aff97; 6'd50: k=32'hab9423a7; 6'd51: k=32'hfc93a039;
            6'd52: k=32'h655b59c3; 6'd53: k=32'h8f0ccc92; 6'd54: k=32'hffeff47d; 6'd55: k=32'h85845dd1;
            6'd56: k=32'h6fa87e4f; 6'd57: k=32'hfe2ce6e0; 6'd58: k=32'ha3014314; 6'd59: k=32'h4e0811a1;
            6'd60: k=32'hf7537e82; 6'd61: k=32'hbd3af235; 6'd62: k=32'h2ad7d2bb; default: k=32'heb86d391;
         endcase
         return k;
      end
   endfunction

   function automatic logic [4:0] rot_amt(input logic [5:0] r);
      logic [4:0] s;
      begin
         case ({r[5:4], r[1:0]})
            4'h0: s=5'd7;  4'h1: s=5'd12; 4'h2: s=5'd17; 4'h3: s=5'd22;
            4'h4: s=5'd5;  4'h5: s=5'd9;  4'h6: s=5'd14; 4'h7: s=5'd20;
            4'h8: s=5'd4;  4'h9: s=5'd11; 4'ha: s=5'd16; 4'hb: s=5'd23;
            4'hc: s=5'd6;  4'hd: s=5'd10; 4'he: s=5'd15; default: s=5'd21;
         endcase
         return s;
      end
   endfunction

   // message word index used by round r
   function automatic logic [3:0] msg_index(input logic [5:0] r);
      logic [3:0] g;
      begin
         case (r[5:4])
            2'd0: g = r[3:0];
            2'd1: g = 4'(({2'b00, r[3:0]} * 6'd5) + 6'd1);
            2'd2: g = 4'(({2'b00, r[3:0]} * 6'd3) + 6'd5);
            default: g = 4'({2'b00, r[3:0]} * 6'd7);
         endcase
         return g;
      end
   endfunction
endpackage
`default_nettype wire

// ===== hdl/md5_like_block_hash.sv =====
// Top level of the MD5-like block hash: byte packer, block memory, sequencer.
// Depends on mlbh_pkg and mlbh_round.
//
//  channel | dir | fields
//  req_    | in  | tdata[7:0]=data_byte, tdata[8]=restart, tuser=has_byte, tlast=last_byte
//  rsp_    | out | tdata = digest_a .. digest_d, lowest first
//
// A byte that neither fills a block nor is last leaves req_tready high. A
// full block holds off req_tready while it primes the block-memory read,
// runs 64 rounds at one per cycle through the single round unit and does
// the chaining add. A last item pads one word per cycle to the block end,
// runs the block, and a zero block again when the pad lands in byte 63.
// Synchronous reset clears control and loads the IV; no item is taken while a
// digest waits on rsp_.
`default_nettype none
module md5_like_block_hash (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [15:0]  req_tdata,  // data_byte[7:0], restart[8], zeros
   input  wire logic         req_tuser,  // has_byte
   input  wire logic         req_tlast,  // last_byte
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [127:0]      rsp_tdata   // digest_a, digest_b, digest_c, digest_d
);
   mlbh_pkg::state_type st_ff, st_in;
   logic [31:0] mem [16];        // block words, registered read
   logic [31:0] rd_ff;
   logic [31:0] wbuf_ff;         // word being assembled
   logic [5:0]  pos_ff, pos_in;  // byte position
   logic [5:0]  epos;            // byte position after restart
   logic [6:0]  cnt_ff, cnt_in;  // round counter, 65 = add
   logic        xtra_ff, xtra_in;
   logic        mark_ff, mark_in; // pad marker still owed to the next pad word
   logic        padp_ff, padp_in, lastp_ff, lastp_in;
   logic        acc;
   logic [7:0]  dbyte;
   logic        has, rst_it;
   logic        we;
   logic [3:0]  wa;
   logic [31:0] wd;
   logic [3:0]  ra;
   logic [31:0] wcur, wpad;
   logic [127:0] chain;
   mlbh_pkg::ctl_type ctl;
   logic        step, finish;

   assign dbyte  = req_tdata[7:0];
   assign has    = req_tuser;
   assign rst_it = req_tdata[8];
   assign acc    = req_tvalid && req_tready;
   assign req_tready = (st_ff == mlbh_pkg::ST_IDLE);
   assign epos   = rst_it ? 6'd0 : pos_ff;

   // word with the new byte merged; restart drops partial bytes
   always_comb begin
      wcur = (epos[1:0] == 2'd0) ? 32'd0 : wbuf_ff;
      case (epos[1:0])
         2'd0: wcur[7:0]   = dbyte;
         2'd1: wcur[15:8]  = dbyte;
         2'd2: wcur[23:16] = dbyte;
         default: wcur[31:24] = dbyte;
      endcase
   end

   // pad word at byte position ppos from the assembled buffer
   logic [5:0] ppos;
   logic [31:0] pbase;
   always_comb begin
      ppos  = epos + {5'd0, has};
      pbase = has ? wcur : ((epos[1:0] == 2'd0) ? 32'd0 : wbuf_ff);
      case (ppos[1:0])
         2'd0: wpad = {24'd0, mlbh_pkg::PAD_MARK};
         2'd1: wpad = {16'd0, mlbh_pkg::PAD_MARK, pbase[7:0]};
         2'd2: wpad = {8'd0, mlbh_pkg::PAD_MARK, pbase[15:0]};
         default: wpad = {mlbh_pkg::PAD_MARK, pbase[23:0]};
      endcase
   end

   // word for round cnt is registered in the cycle before that round uses it
   assign ra = mlbh_pkg::msg_index(cnt_ff[5:0]);

   always_comb begin
      st_in = st_ff; pos_in = pos_ff; cnt_in = cnt_ff; xtra_in = xtra_ff;
      mark_in = mark_ff;
      we = 1'b0; wa = pos_ff[5:2]; wd = wcur;
      ctl = '0; step = 1'b0; finish = 1'b0;
      case (st_ff)
         mlbh_pkg::ST_IDLE: begin
            cnt_in = 7'd0;
            if (acc) begin
               pos_in = epos;
               if (has) begin
                  we = 1'b1; wa = epos[5:2]; wd = wcur;
                  pos_in = epos + 6'd1;
               end
               if (req_tlast && !(has && pos_in == 6'd0)) begin
                  xtra_in = (ppos == 6'd63);
                  if (has && ppos[1:0] == 2'd0) begin
                     // byte closed its word: marker opens the next word
                     mark_in = 1'b1; pos_in = ppos; st_in = mlbh_pkg::ST_PAD;
                  end else begin
                     // pad marker lands in current word
                     we = 1'b1; wa = ppos[5:2]; wd = wpad;
                     pos_in = {ppos[5:2] + 4'd1, 2'b00};
                     st_in = (ppos[5:2] == 4'd15) ? mlbh_pkg::ST_RUN : mlbh_pkg::ST_PAD;
                     ctl.start = (ppos[5:2] == 4'd15);
                  end
               end else if (has && pos_in == 6'd0) begin
                  // block full; pad (if last) goes into a fresh block
                  xtra_in = 1'b0;
                  st_in = mlbh_pkg::ST_RUN; ctl.start = 1'b1;
               end
            end
         end
         mlbh_pkg::ST_PAD: begin
            we = 1'b1; wa = pos_ff[5:2]; ctl.clear = 1'b1;
            wd = mark_ff ? {24'd0, mlbh_pkg::PAD_MARK} : 32'd0;
            mark_in = 1'b0;
            pos_in = pos_ff + 6'd4;
            if (pos_ff[5:2] == 4'd15) begin
               st_in = mlbh_pkg::ST_RUN; ctl.start = 1'b1;
            end
         end
         mlbh_pkg::ST_RUN: begin
            // cnt 0: memory read primed; 1..64: rounds; 65: add
            cnt_in = cnt_ff + 7'd1;
            step = (cnt_ff != 7'd0) && (cnt_ff != 7'd65);
            if (cnt_ff == 7'd65) begin
               finish = 1'b1; cnt_in = 7'd0;
               if (xtra_ff) begin
                  xtra_in = 1'b0; pos_in = 6'd0; st_in = mlbh_pkg::ST_ZERO;
               end else if (lastp_ff) begin
                  st_in = mlbh_pkg::ST_OUT; pos_in = 6'd0;
               end else if (padp_ff) begin
                  // full block ended on a last item: pad fresh block
                  we = 1'b1; wa = 4'd0; wd = {24'd0, mlbh_pkg::PAD_MARK};
                  pos_in = 6'd4; st_in = mlbh_pkg::ST_PAD;
               end else begin
                  st_in = mlbh_pkg::ST_IDLE;
               end
            end
         end
         mlbh_pkg::ST_ZERO: begin
            we = 1'b1; wa = pos_ff[5:2]; wd = 32'd0; ctl.clear = 1'b1;
            pos_in = pos_ff + 6'd4;
            if (pos_ff[5:2] == 4'd15) begin
               st_in = mlbh_pkg::ST_RUN; ctl.start = 1'b1; pos_in = 6'd0;
            end
         end
         mlbh_pkg::ST_OUT: begin
            pos_in = 6'd0;
            if (rsp_tready) st_in = mlbh_pkg::ST_IDLE;
         end
         default: st_in = mlbh_pkg::ST_IDLE;
      endcase
      if (st_ff != mlbh_pkg::ST_RUN) cnt_in = 7'd0;
   end

   // flags: padp = block still needs padding, lastp = this run ends the message
   always_comb begin
      padp_in = padp_ff; lastp_in = lastp_ff;
      if (st_ff == mlbh_pkg::ST_IDLE && acc) begin
         padp_in  = req_tlast && has && (epos == 6'd63);
         lastp_in = req_tlast && !padp_in;
      end else if (st_ff == mlbh_pkg::ST_RUN && cnt_ff == 7'd65 && padp_ff) begin
         padp_in = 1'b0; lastp_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= mlbh_pkg::ST_IDLE; pos_ff <= '0; cnt_ff <= '0;
         xtra_ff <= 1'b0; padp_ff <= 1'b0; lastp_ff <= 1'b0; mark_ff <= 1'b0;
      end else begin
         st_ff <= st_in; pos_ff <= pos_in; cnt_ff <= cnt_in;
         xtra_ff <= xtra_in; padp_ff <= padp_in; lastp_ff <= lastp_in;
         mark_ff <= mark_in;
      end
   end

   always_ff @(posedge clock) begin
      if (we) mem[wa] <= wd;
      rd_ff <= mem[ra];
      if (acc && has) wbuf_ff <= wcur;
   end

   mlbh_round u_round (
      .clock    (clock),
      .reset    (reset),
      .load_iv  (acc && rst_it),
      .ctl      (ctl),
      .step     (step),
      .rnd      (6'(cnt_ff - 7'd1)),
      .msg_word (rd_ff),
      .finish   (finish),
      .chain    (chain)
   );

   assign rsp_tvalid = (st_ff == mlbh_pkg::ST_OUT);
   assign rsp_tdata  = chain;

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !rsp_tvalid) else $error("accepting while digest pending");
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 7'd65) else $error("round counter overrun");
   a_run_start: assert property (@(posedge clock) disable iff (reset)
      ctl.start |=> st_ff == mlbh_pkg::ST_RUN) else $error("start without run");
endmodule
`default_nettype wire

// ===== hdl/mlbh_round.sv =====
// One MD5 round per cycle while step is high, on registered A..D, plus chaining words and final add.
// Depends on mlbh_pkg.
`default_nettype none
module mlbh_round (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              load_iv,
   input  wire mlbh_pkg::ctl_type ctl,
   input  wire logic              step,
   input  wire logic [5:0]        rnd,
   input  wire logic [31:0]       msg_word,
   input  wire logic              finish,
   output logic [127:0]           chain
);
   logic [31:0] ch_ff [4];
   logic [31:0] a_ff, b_ff, c_ff, d_ff;
   logic [31:0] f, sum, rot;
   logic [63:0] dbl;

   always_comb begin
      case (rnd[5:4])
         2'd0: f = (b_ff & c_ff) | (~b_ff & d_ff);
         2'd1: f = (d_ff & b_ff) | (~d_ff & c_ff);
         2'd2: f = b_ff ^ c_ff ^ d_ff;
         default: f = c_ff ^ (b_ff | ~d_ff);
      endcase
      sum = f + a_ff + mlbh_pkg::kconst(rnd) + msg_word;
      dbl = {sum, sum} << mlbh_pkg::rot_amt(rnd);
      rot = dbl[63:32];
   end

   always_ff @(posedge clock) begin
      if (ctl.start) begin
         a_ff <= ch_ff[0]; b_ff <= ch_ff[1]; c_ff <= ch_ff[2]; d_ff <= ch_ff[3];
      end else if (step) begin
         a_ff <= d_ff; d_ff <= c_ff; c_ff <= b_ff; b_ff <= b_ff + rot;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || load_iv) begin
         ch_ff[0] <= mlbh_pkg::IV_A; ch_ff[1] <= mlbh_pkg::IV_B;
         ch_ff[2] <= mlbh_pkg::IV_C; ch_ff[3] <= mlbh_pkg::IV_D;
      end else if (finish) begin
         ch_ff[0] <= ch_ff[0] + a_ff; ch_ff[1] <= ch_ff[1] + b_ff;
         ch_ff[2] <= ch_ff[2] + c_ff; ch_ff[3] <= ch_ff[3] + d_ff;
      end
   end

   assign chain = {ch_ff[3], ch_ff[2], ch_ff[1], ch_ff[0]};
endmodule
`default_nettype wire
